// ----- design/g3mn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g3mn_pkg
// Types, constants and helpers shared by the 3D Moore neighbour index block.
// ----------------------------------------------------------------------------
package g3mn_pkg;

  localparam int MAX_AXIS    = 256;
  localparam int COORD_W     = 8;
  localparam int CNT_W       = 9;
  localparam int SIZE_W      = 16;
  localparam int IDX_W       = 24;
  localparam int CTR_W       = 25;
  localparam int PLANE_W     = 2 * CNT_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = SIZE_W;
  localparam int NB_SLOTS    = 27;
  localparam int SLOT_W      = $clog2(NB_SLOTS + 1);
  localparam int CENTRE_SLOT = 13;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_COUNT   = 3'd0,
    REG_Y_COUNT   = 3'd1,
    REG_Z_COUNT   = 3'd2,
    REG_WRAP_MODE = 3'd3,
    REG_CELL_SIZE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0]  x_count;
    logic [CNT_W-1:0]  y_count;
    logic [CNT_W-1:0]  z_count;
    logic              wrap_mode;
    logic [SIZE_W-1:0] cell_size;
  } cfg_t;

  // one classified cell, ready for the neighbour walk
  typedef struct packed {
    logic                      bad;
    logic [IDX_W-1:0]          ci;
    logic [CTR_W-1:0]          cx;
    logic [CTR_W-1:0]          cy;
    logic [CTR_W-1:0]          cz;
    logic [NB_SLOTS-1:0]       mask;
    logic [2:0][CNT_W-1:0]     xs;
    logic [2:0][CNT_W-1:0]     ys;
    logic [2:0][CNT_W-1:0]     zs;
    logic [CNT_W-1:0]          xn;
    logic [PLANE_W-1:0]        plane;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = c;
    if (c == '0) r = CNT_W'(1);
    else if (int'(c) > MAX_AXIS) r = CNT_W'(MAX_AXIS);
    return r;
  endfunction

endpackage

// ----- design/g3mn_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g3mn_front
// Takes a cell request, checks it against the counts, works out the linear
// index, centres, neighbour coordinates and neighbour mask, and queues it.
// ----------------------------------------------------------------------------
module g3mn_front (
  input  logic                          clk,
  input  logic                          rst,
  input  g3mn_pkg::cfg_t                cfg,
  input  logic                          start,
  input  logic [g3mn_pkg::COORD_W-1:0]  cell_x,
  input  logic [g3mn_pkg::COORD_W-1:0]  cell_y,
  input  logic [g3mn_pkg::COORD_W-1:0]  cell_z,
  output logic                          busy,
  input  g3mn_pkg::q_status_t           q_status,
  output logic                          push,
  output g3mn_pkg::job_t                job
);
  import g3mn_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CALC1 = 3'b010,
    S_CALC2 = 3'b100
  } front_state_t;

  front_state_t state, state_next;

  logic [COORD_W-1:0] x, y, z;

  // calc1 results
  logic                  bad;
  logic [CNT_W-1:0]      xn;
  logic [PLANE_W-1:0]    plane;
  logic [COORD_W+CNT_W-1:0] yx;
  logic [CTR_W-1:0]      cx, cy, cz;
  logic [NB_SLOTS-1:0]   mask;
  logic [2:0][CNT_W-1:0] xs, ys, zs;

  logic [CNT_W-1:0]      xn_c, yn_c, zn_c;
  logic                  bad_c;
  logic [2:0]            vx, vy, vz;
  logic [NB_SLOTS-1:0]   mask_c;
  logic [2:0][CNT_W-1:0] xs_c, ys_c, zs_c;
  logic [COORD_W+PLANE_W:0] ci_sum;

  function automatic logic [2:0][CNT_W-1:0] axis_coords(
    input logic [COORD_W-1:0] c, input logic [CNT_W-1:0] n);
    logic [2:0][CNT_W-1:0] r;
    logic [CNT_W-1:0]      cw;
    cw   = CNT_W'(c);
    r[0] = (cw == '0) ? n - 1'b1 : cw - 1'b1;
    r[1] = cw;
    r[2] = (cw + 1'b1 >= n) ? '0 : cw + 1'b1;
    return r;
  endfunction

  function automatic logic [2:0] axis_ok(
    input logic [COORD_W-1:0] c, input logic [CNT_W-1:0] n, input logic w);
    logic [2:0]       r;
    logic [CNT_W-1:0] cw;
    cw   = CNT_W'(c);
    r[0] = (cw != '0) || w;
    r[1] = 1'b1;
    r[2] = (cw + 1'b1 < n) || w;
    return r;
  endfunction

  always_comb begin
    xn_c  = eff_count(cfg.x_count);
    yn_c  = eff_count(cfg.y_count);
    zn_c  = eff_count(cfg.z_count);
    bad_c = (CNT_W'(x) >= xn_c) || (CNT_W'(y) >= yn_c) || (CNT_W'(z) >= zn_c);
    xs_c  = axis_coords(x, xn_c);
    ys_c  = axis_coords(y, yn_c);
    zs_c  = axis_coords(z, zn_c);
    vx    = axis_ok(x, xn_c, cfg.wrap_mode);
    vy    = axis_ok(y, yn_c, cfg.wrap_mode);
    vz    = axis_ok(z, zn_c, cfg.wrap_mode);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          mask_c[9*i + 3*j + k] = vx[i] & vy[j] & vz[k];
        end
      end
    end
    mask_c[CENTRE_SLOT] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      x <= cell_x;
      y <= cell_y;
      z <= cell_z;
    end
    if (state == S_CALC1) begin
      bad   <= bad_c;
      xn    <= xn_c;
      plane <= xn_c * yn_c;
      yx    <= y * xn_c;
      cx    <= bad_c ? '0 : cfg.cell_size * {x, 1'b1};
      cy    <= bad_c ? '0 : cfg.cell_size * {y, 1'b1};
      cz    <= bad_c ? '0 : cfg.cell_size * {z, 1'b1};
      mask  <= mask_c;
      xs    <= xs_c;
      ys    <= ys_c;
      zs    <= zs_c;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_CALC1;
      S_CALC1: state_next = S_CALC2;
      S_CALC2: if (!q_status.full) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy   = (state != S_IDLE);
  assign push   = (state == S_CALC2) && !q_status.full;
  assign ci_sum = (COORD_W+PLANE_W+1)'(z) * (COORD_W+PLANE_W+1)'(plane)
                + (COORD_W+PLANE_W+1)'(yx) + (COORD_W+PLANE_W+1)'(x);

  always_comb begin
    job.bad   = bad;
    job.ci    = bad ? '0 : ci_sum[IDX_W-1:0];
    job.cx    = cx;
    job.cy    = cy;
    job.cz    = cz;
    job.mask  = mask;
    job.xs    = xs;
    job.ys    = ys;
    job.zs    = zs;
    job.xn    = xn;
    job.plane = plane;
  end

endmodule

// ----- design/g3mn_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g3mn_queue
// Short register queue of classified cells between front and back.
// ----------------------------------------------------------------------------
module g3mn_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  g3mn_pkg::job_t       push_job,
  input  logic                 pop,
  output g3mn_pkg::job_t       head_job,
  output g3mn_pkg::q_status_t  status
);
  import g3mn_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign status.empty = (count == '0);
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_job     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && status.empty)) else $error("queue pop while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow push");

endmodule

// ----- design/g3mn_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g3mn_back
// Walks the neighbour offsets of each queued cell and emits the header and
// the neighbour indices, at most one per cycle, through two register stages.
// ----------------------------------------------------------------------------
module g3mn_back (
  input  logic                          clk,
  input  logic                          rst,
  input  g3mn_pkg::q_status_t           q_status,
  input  g3mn_pkg::job_t                head_job,
  output logic                          pop,
  output logic                          valid,
  output logic                          is_header,
  output logic                          bad_cell,
  output logic [g3mn_pkg::IDX_W-1:0]    cell_index,
  output logic [g3mn_pkg::IDX_W-1:0]    nbr_index,
  output logic [g3mn_pkg::CTR_W-1:0]    center_x,
  output logic [g3mn_pkg::CTR_W-1:0]    center_y,
  output logic [g3mn_pkg::CTR_W-1:0]    center_z,
  output logic                          last
);
  import g3mn_pkg::*;

  localparam int PY_W  = CNT_W + CNT_W;
  localparam int PZ_W  = CNT_W + PLANE_W;
  localparam int SUM_W = PZ_W + 1;

  job_t        cur;
  logic        w_active, w_hdr;
  logic [1:0]  dx, dy, dz;

  logic [SLOT_W-1:0]   slot;
  logic [NB_SLOTS-1:0] rest;
  logic                hit, last_c, finish;
  logic [CNT_W-1:0]    nx, ny, nz;

  // stage 1
  logic               s1_valid, s1_hdr, s1_last, s1_bad;
  logic [IDX_W-1:0]   s1_ci;
  logic [CTR_W-1:0]   s1_cx, s1_cy, s1_cz;
  logic [CNT_W-1:0]   s1_nx;
  logic [PY_W-1:0]    s1_py;
  logic [PZ_W-1:0]    s1_pz;
  logic [SUM_W-1:0]   nb_sum;

  always_comb begin
    slot   = SLOT_W'(dx) * SLOT_W'(9) + SLOT_W'(dy) * SLOT_W'(3) + SLOT_W'(dz);
    rest   = cur.mask >> (slot + 1'b1);
    nx     = cur.xs[dx];
    ny     = cur.ys[dy];
    nz     = cur.zs[dz];
    hit    = w_hdr ? 1'b1 : cur.mask[slot];
    last_c = w_hdr ? (cur.bad || cur.mask == '0) : (rest == '0);
    finish = w_active && hit && last_c;
    pop    = !q_status.empty && (!w_active || finish);
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_active <= 1'b0;
      w_hdr    <= 1'b0;
      dx       <= '0;
      dy       <= '0;
      dz       <= '0;
    end else if (pop) begin
      w_active <= 1'b1;
      w_hdr    <= 1'b1;
      dx       <= '0;
      dy       <= '0;
      dz       <= '0;
    end else if (finish) begin
      w_active <= 1'b0;
    end else if (w_active) begin
      if (w_hdr) begin
        w_hdr <= 1'b0;
      end else if (dx == 2'd1 && dy == 2'd1 && dz == 2'd0) begin
        dz <= 2'd2;
      end else if (dz != 2'd2) begin
        dz <= dz + 1'b1;
      end else begin
        dz <= '0;
        if (dy != 2'd2) begin
          dy <= dy + 1'b1;
        end else begin
          dy <= '0;
          dx <= dx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_hdr  <= w_hdr;
    s1_last <= last_c;
    s1_bad  <= cur.bad;
    s1_ci   <= cur.ci;
    s1_cx   <= cur.cx;
    s1_cy   <= cur.cy;
    s1_cz   <= cur.cz;
    s1_nx   <= nx;
    s1_py   <= ny * cur.xn;
    s1_pz   <= nz * cur.plane;
  end

  assign nb_sum = SUM_W'(s1_pz) + SUM_W'(s1_py) + SUM_W'(s1_nx);

  always_ff @(posedge clk) begin
    is_header  <= s1_hdr;
    bad_cell   <= s1_hdr & s1_bad;
    cell_index <= s1_ci;
    nbr_index  <= s1_hdr ? '0 : nb_sum[IDX_W-1:0];
    center_x   <= s1_cx;
    center_y   <= s1_cy;
    center_z   <= s1_cz;
    last       <= s1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      valid    <= 1'b0;
    end else begin
      s1_valid <= w_active && hit;
      valid    <= s1_valid;
    end
  end

  a_skip_centre: assert property (@(posedge clk) disable iff (rst)
    (w_active && !w_hdr) |-> !(dx == 2'd1 && dy == 2'd1 && dz == 2'd1))
    else $error("walker reached the centre offset");
  a_bad_is_single: assert property (@(posedge clk) disable iff (rst)
    (valid && bad_cell) |-> (is_header && last))
    else $error("flagged header not final");
  a_nb_not_bad: assert property (@(posedge clk) disable iff (rst)
    (valid && !is_header) |-> !bad_cell)
    else $error("neighbour result carries bad flag");
  a_pipe_carry: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> valid) else $error("result lost between stages");

endmodule

// ----- design/grid3d_moore_neighbor_indices.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid3d_moore_neighbor_indices
// 3D Moore neighbour index generator with optional periodic boundary.
// ----------------------------------------------------------------------------
// Requests: a cell (cell_x, cell_y, cell_z) is taken at a clock edge with
// start high and busy low. busy stays high through the classify states
// CALC1 and CALC2, and in CALC2 while the request queue (two deep) is full.
// Results: one per cycle while valid is high, header first (is_header), then
// the neighbour indices in offset order, last on the final one. A cell off
// the grid gives a single flagged header. The header passes through the
// classify registers, the queue, the walker and its register stages.
// Walker: the neighbour walker takes the header first and then steps
// through the offsets in order, skipping the centre, up to the last surviving
// neighbour; a flagged cell gets only the header. The front classifies a
// cell and works ahead of the walker.
// Registers: cfg_we writes cfg_data to the register at cfg_index; the user must
// write only while no request is in flight, which the block does not enforce.
// Reset: clears the queue, walker and output strobe; counts go to 1,
// wrap_mode to 0 and cell_size to 256. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module grid3d_moore_neighbor_indices (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [g3mn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [g3mn_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            start,
  output logic                            busy,
  input  logic [g3mn_pkg::COORD_W-1:0]    cell_x,
  input  logic [g3mn_pkg::COORD_W-1:0]    cell_y,
  input  logic [g3mn_pkg::COORD_W-1:0]    cell_z,
  output logic                            valid,
  output logic                            is_header,
  output logic                            bad_cell,
  output logic [g3mn_pkg::IDX_W-1:0]      cell_index,
  output logic [g3mn_pkg::IDX_W-1:0]      nbr_index,
  output logic [g3mn_pkg::CTR_W-1:0]      center_x,
  output logic [g3mn_pkg::CTR_W-1:0]      center_y,
  output logic [g3mn_pkg::CTR_W-1:0]      center_z,
  output logic                            last
);
  import g3mn_pkg::*;

  cfg_t      cfg;
  job_t      push_job, head_job;
  logic      push, pop;
  q_status_t q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_count   <= CNT_W'(1);
      cfg.y_count   <= CNT_W'(1);
      cfg.z_count   <= CNT_W'(1);
      cfg.wrap_mode <= 1'b0;
      cfg.cell_size <= SIZE_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_COUNT:   cfg.x_count   <= cfg_data[CNT_W-1:0];
        REG_Y_COUNT:   cfg.y_count   <= cfg_data[CNT_W-1:0];
        REG_Z_COUNT:   cfg.z_count   <= cfg_data[CNT_W-1:0];
        REG_WRAP_MODE: cfg.wrap_mode <= cfg_data[0];
        REG_CELL_SIZE: cfg.cell_size <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  g3mn_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .start    (start),
    .cell_x   (cell_x),
    .cell_y   (cell_y),
    .cell_z   (cell_z),
    .busy     (busy),
    .q_status (q_status),
    .push     (push),
    .job      (push_job)
  );

  g3mn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  g3mn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .head_job   (head_job),
    .pop        (pop),
    .valid      (valid),
    .is_header  (is_header),
    .bad_cell   (bad_cell),
    .cell_index (cell_index),
    .nbr_index  (nbr_index),
    .center_x   (center_x),
    .center_y   (center_y),
    .center_z   (center_z),
    .last       (last)
  );

endmodule
